[rtl/complex_horner_eval_deflate_macros.svh]
// Assertion helpers for the evaluator modules.
// Each module that uses them must have signals named clock and reset.
`ifndef COMPLEX_HORNER_EVAL_DEFLATE_MACROS_SVH
`define COMPLEX_HORNER_EVAL_DEFLATE_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define CHDE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// A condition that must never be true outside reset.
`define CHDE_NEVER(label, expr, msg) \
   `CHDE_ASSERT(label, !(expr), msg)

`endif

[rtl/chde_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package chde_pkg;

   localparam int FRAC_BITS_DEFAULT   = 16;
   localparam int ACC_WIDTH_DEFAULT   = 48;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Coefficients and the evaluation point are 32-bit words.
   localparam int COEF_W     = 32;
   // Result fields are always 48 bits wide.
   localparam int OUT_W      = 48;
   // Accumulators are split here into a low part and a high part for the multipliers.
   localparam int SPLIT_W    = 32;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Accumulator lanes.
   localparam int UNIT_VALUE  = 0;
   localparam int UNIT_DERIV1 = 1;
   localparam int UNIT_DERIV2 = 2;
   localparam int UNITS       = 3;

   typedef enum logic {
      ITEM_INNER,
      ITEM_FINAL
   } item_kind_type;

   typedef enum logic {
      REG_POINT_RE,
      REG_POINT_IM
   } csr_reg_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] re;
      logic signed [COEF_W-1:0] im;
   } point_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] coef_re;
      logic signed [COEF_W-1:0] coef_im;
      item_kind_type            kind;
   } queue_entry_type;

endpackage

`default_nettype wire

[rtl/complex_horner_eval_deflate.sv]
// Complex Horner evaluator with derivatives and deflation. Coefficients of a
// polynomial arrive one per req beat, highest degree first, with req_last_coef
// set on the constant term; the evaluation point q is written beforehand into
// the point_re register (byte address 0) and the point_im register (byte
// address 4), both signed Q16.16 by default. Every coefficient beat yields one
// rsp beat: before the last, rsp_value is the next quotient coefficient of
// p(x)/(x-q) and the derivative fields are the running sums; on the last beat
// rsp_value is p(q), rsp_deriv1 is p'(q), rsp_deriv2 is p''(q) and
// rsp_is_final is set, after which the accumulators and the saturation flag
// start over. Accumulators are saturating Q32.16 words with products truncated
// toward minus infinity; rsp_saturated reports any clamp in the current
// polynomial. The input side takes a beat every cycle until the four-entry
// queue is full. The back end works on one coefficient at a time: the
// accumulator update loop runs through a split 48 by 32 multiply stage, a
// product assembly stage and a saturating add stage before the next
// coefficient can read the new accumulators, and the add stage waits while
// a stalled result fills the output register. The output register holds a
// finished result while the next coefficient is already being worked on.
`timescale 1ns / 1ps
`default_nettype none

module complex_horner_eval_deflate #(
   parameter int FRAC_BITS   = chde_pkg::FRAC_BITS_DEFAULT,
   parameter int ACC_WIDTH   = chde_pkg::ACC_WIDTH_DEFAULT,
   parameter int QUEUE_DEPTH = chde_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // Configuration port.
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [chde_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [chde_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [chde_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready,
   // Coefficient channel.
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [chde_pkg::COEF_W-1:0] req_coef_re,
   input  logic signed [chde_pkg::COEF_W-1:0] req_coef_im,
   input  logic                               req_last_coef,
   // Result channel.
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [chde_pkg::OUT_W-1:0]  rsp_value_re,
   output logic signed [chde_pkg::OUT_W-1:0]  rsp_value_im,
   output logic signed [chde_pkg::OUT_W-1:0]  rsp_deriv1_re,
   output logic signed [chde_pkg::OUT_W-1:0]  rsp_deriv1_im,
   output logic signed [chde_pkg::OUT_W-1:0]  rsp_deriv2_re,
   output logic signed [chde_pkg::OUT_W-1:0]  rsp_deriv2_im,
   output logic                               rsp_is_final,
   output logic                               rsp_saturated
);

   // The point is held in the front end and read by the back end. The user must
   // change it only while no coefficient is in flight; the block does not enforce it.
   chde_pkg::point_type       point;
   logic                      push_valid;
   chde_pkg::queue_entry_type push_entry;
   logic                      queue_full;
   logic                      pop_valid;
   logic                      pop_ready;
   chde_pkg::queue_entry_type pop_entry;

   // The front end owns the registers and accepts coefficient beats, tagging
   // the constant term so the back end knows when to finish.
   chde_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_coef_re   (req_coef_re),
      .req_coef_im   (req_coef_im),
      .req_last_coef (req_last_coef),
      .point         (point),
      .push_valid    (push_valid),
      .push_entry    (push_entry),
      .queue_full    (queue_full)
   );

   // The queue lets the input keep streaming while the back end works
   // through its update loop or waits on a stalled result.
   chde_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop_ready  (pop_ready),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry)
   );

   // The back end runs the three complex multiply-adds and owns the
   // output register.
   chde_back #(
      .FRAC_BITS (FRAC_BITS),
      .ACC_WIDTH (ACC_WIDTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .point         (point),
      .pop_valid     (pop_valid),
      .pop_entry     (pop_entry),
      .pop_ready     (pop_ready),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_value_re  (rsp_value_re),
      .rsp_value_im  (rsp_value_im),
      .rsp_deriv1_re (rsp_deriv1_re),
      .rsp_deriv1_im (rsp_deriv1_im),
      .rsp_deriv2_re (rsp_deriv2_re),
      .rsp_deriv2_im (rsp_deriv2_im),
      .rsp_is_final  (rsp_is_final),
      .rsp_saturated (rsp_saturated)
   );

endmodule

`default_nettype wire

[rtl/chde_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module chde_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [chde_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [chde_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [chde_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [chde_pkg::COEF_W-1:0] req_coef_re,
   input  logic signed [chde_pkg::COEF_W-1:0] req_coef_im,
   input  logic                               req_last_coef,
   output chde_pkg::point_type                point,
   output logic                               push_valid,
   output chde_pkg::queue_entry_type          push_entry,
   input  logic                               queue_full
);

   chde_pkg::point_type   point_ff;
   chde_pkg::point_type   point_in;
   chde_pkg::csr_reg_type csr_sel;
   logic                  csr_write;
   logic [chde_pkg::CSR_DATA_W-1:0] csr_rd_word;

   assign csr_sel    = chde_pkg::csr_reg_type'(csr_paddr[2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      point_in = point_ff;
      if (csr_write) begin
         unique case (csr_sel)
            chde_pkg::REG_POINT_RE: point_in.re = csr_pwdata;
            chde_pkg::REG_POINT_IM: point_in.im = csr_pwdata;
            default:                point_in    = point_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_ff <= '0;
      end else begin
         point_ff <= point_in;
      end
   end

   always_comb begin
      unique case (csr_sel)
         chde_pkg::REG_POINT_RE: csr_rd_word = point_ff.re;
         chde_pkg::REG_POINT_IM: csr_rd_word = point_ff.im;
         default:                csr_rd_word = '0;
      endcase
      // Only word-aligned addresses hold a register.
      csr_prdata = (csr_paddr[1:0] == 2'b00) ? csr_rd_word : '0;
   end

   assign point = point_ff;

   // A beat is taken whenever the queue has room; the last coefficient is
   // tagged so the back end knows to finish the evaluation.
   assign req_stall          = queue_full;
   assign push_valid         = req_valid && !queue_full;
   assign push_entry.coef_re = req_coef_re;
   assign push_entry.coef_im = req_coef_im;
   assign push_entry.kind    = req_last_coef ? chde_pkg::ITEM_FINAL : chde_pkg::ITEM_INNER;

endmodule

`default_nettype wire

[rtl/chde_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module chde_queue #(
   parameter int DEPTH = chde_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   input  chde_pkg::queue_entry_type push_entry,
   output logic                      full,
   input  logic                      pop_ready,
   output logic                      pop_valid,
   output chde_pkg::queue_entry_type pop_entry
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   chde_pkg::queue_entry_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = entries_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_ready && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

[rtl/chde_back.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "complex_horner_eval_deflate_macros.svh"

module chde_back #(
   parameter int FRAC_BITS = chde_pkg::FRAC_BITS_DEFAULT,
   parameter int ACC_WIDTH = chde_pkg::ACC_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  chde_pkg::point_type               point,
   input  logic                              pop_valid,
   input  chde_pkg::queue_entry_type         pop_entry,
   output logic                              pop_ready,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [chde_pkg::OUT_W-1:0] rsp_value_re,
   output logic signed [chde_pkg::OUT_W-1:0] rsp_value_im,
   output logic signed [chde_pkg::OUT_W-1:0] rsp_deriv1_re,
   output logic signed [chde_pkg::OUT_W-1:0] rsp_deriv1_im,
   output logic signed [chde_pkg::OUT_W-1:0] rsp_deriv2_re,
   output logic signed [chde_pkg::OUT_W-1:0] rsp_deriv2_im,
   output logic                              rsp_is_final,
   output logic                              rsp_saturated
);

   localparam int UNITS   = chde_pkg::UNITS;
   localparam int TERMS   = 4;
   // Product terms of acc * q: re*re, im*im, re*im, im*re.
   localparam int TERM_RR = 0;
   localparam int TERM_II = 1;
   localparam int TERM_RI = 2;
   localparam int TERM_IR = 3;

   localparam int SPLIT_W = chde_pkg::SPLIT_W;
   localparam int COEF_W  = chde_pkg::COEF_W;
   localparam int OUT_W   = chde_pkg::OUT_W;
   localparam int HI_W    = ACC_WIDTH - SPLIT_W;
   localparam int LO_W    = SPLIT_W + 1;
   localparam int PL_W    = LO_W + COEF_W;
   localparam int PH_W    = HI_W + COEF_W;
   localparam int FULL_W  = ACC_WIDTH + COEF_W;
   localparam int PROD_W  = FULL_W - FRAC_BITS;
   localparam int SUM_W   = PROD_W + 2;
   localparam int EXT_W   = (ACC_WIDTH > OUT_W) ? ACC_WIDTH : OUT_W;

   localparam logic [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH - 1){1'b1}}};
   localparam logic [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH - 1){1'b0}}};

   function automatic logic sat_ovf(input logic [SUM_W-1:0] x);
      return (|x[SUM_W-1:ACC_WIDTH-1]) && !(&x[SUM_W-1:ACC_WIDTH-1]);
   endfunction

   function automatic logic [ACC_WIDTH-1:0] sat_val(input logic [SUM_W-1:0] x);
      if (sat_ovf(x)) begin
         return x[SUM_W-1] ? ACC_MIN : ACC_MAX;
      end
      return x[ACC_WIDTH-1:0];
   endfunction

   // Saturating 2*x, equal to doubling the already saturated value.
   function automatic logic dbl_ovf(input logic [SUM_W-1:0] x);
      return (|x[SUM_W-1:ACC_WIDTH-2]) && !(&x[SUM_W-1:ACC_WIDTH-2]);
   endfunction

   function automatic logic [ACC_WIDTH-1:0] dbl_val(input logic [SUM_W-1:0] x);
      if (dbl_ovf(x)) begin
         return x[SUM_W-1] ? ACC_MIN : ACC_MAX;
      end
      return {x[ACC_WIDTH-2:0], 1'b0};
   endfunction

   function automatic logic [OUT_W-1:0] to_out(input logic signed [ACC_WIDTH-1:0] x);
      logic signed [EXT_W-1:0] e;
      e = EXT_W'(x);
      return e[OUT_W-1:0];
   endfunction

   logic signed [ACC_WIDTH-1:0] acc_re_ff [UNITS];
   logic signed [ACC_WIDTH-1:0] acc_im_ff [UNITS];
   logic signed [ACC_WIDTH-1:0] acc_re_in [UNITS];
   logic signed [ACC_WIDTH-1:0] acc_im_in [UNITS];
   logic                        sat_flag_ff, sat_flag_in;

   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic issue, commit;

   logic signed [PL_W-1:0]      lo_prod_ff [UNITS][TERMS];
   logic signed [PL_W-1:0]      lo_prod_in [UNITS][TERMS];
   logic signed [PH_W-1:0]      hi_prod_ff [UNITS][TERMS];
   logic signed [PH_W-1:0]      hi_prod_in [UNITS][TERMS];
   logic signed [ACC_WIDTH-1:0] add_re_ff  [UNITS];
   logic signed [ACC_WIDTH-1:0] add_im_ff  [UNITS];
   logic signed [ACC_WIDTH-1:0] add_re_in  [UNITS];
   logic signed [ACC_WIDTH-1:0] add_im_in  [UNITS];
   logic                        last_ff, last_in;

   logic signed [PROD_W-1:0]    prod_ff [UNITS][TERMS];
   logic signed [PROD_W-1:0]    prod_in [UNITS][TERMS];

   logic [SUM_W-1:0]     sum_re [UNITS];
   logic [SUM_W-1:0]     sum_im [UNITS];
   logic [ACC_WIDTH-1:0] new_re [UNITS];
   logic [ACC_WIDTH-1:0] new_im [UNITS];
   logic                 any_sat, dbl_sat;
   logic [ACC_WIDTH-1:0] d2_re_sel, d2_im_sel;

   logic             out_valid_ff, out_valid_in;
   logic [OUT_W-1:0] out_value_re_ff, out_value_im_ff;
   logic [OUT_W-1:0] out_deriv1_re_ff, out_deriv1_im_ff;
   logic [OUT_W-1:0] out_deriv2_re_ff, out_deriv2_im_ff;
   logic             out_is_final_ff, out_saturated_ff;

   // Only one item is in the multiply loop at a time: the next one needs the
   // accumulators that this one writes.
   assign issue     = pop_valid && !s1_valid_ff && !s2_valid_ff;
   assign pop_ready = issue;
   assign commit    = s2_valid_ff && (!out_valid_ff || !rsp_stall);

   // Issue: split multiplies of every accumulator against the point.
   always_comb begin
      logic signed [ACC_WIDTH-1:0] a;
      logic signed [COEF_W-1:0]    p;
      logic signed [LO_W-1:0]      lo_op;
      logic signed [HI_W-1:0]      hi_op;
      for (int u = 0; u < UNITS; u++) begin
         for (int k = 0; k < TERMS; k++) begin
            a     = (k == TERM_RR || k == TERM_RI) ? acc_re_ff[u] : acc_im_ff[u];
            p     = (k == TERM_RR || k == TERM_IR) ? point.re : point.im;
            lo_op = {1'b0, a[SPLIT_W-1:0]};
            hi_op = a[ACC_WIDTH-1:SPLIT_W];
            lo_prod_in[u][k] = PL_W'(lo_op) * PL_W'(p);
            hi_prod_in[u][k] = PH_W'(hi_op) * PH_W'(p);
         end
      end
      add_re_in[chde_pkg::UNIT_VALUE]  = ACC_WIDTH'(pop_entry.coef_re);
      add_im_in[chde_pkg::UNIT_VALUE]  = ACC_WIDTH'(pop_entry.coef_im);
      add_re_in[chde_pkg::UNIT_DERIV1] = acc_re_ff[chde_pkg::UNIT_VALUE];
      add_im_in[chde_pkg::UNIT_DERIV1] = acc_im_ff[chde_pkg::UNIT_VALUE];
      add_re_in[chde_pkg::UNIT_DERIV2] = acc_re_ff[chde_pkg::UNIT_DERIV1];
      add_im_in[chde_pkg::UNIT_DERIV2] = acc_im_ff[chde_pkg::UNIT_DERIV1];
      last_in = (pop_entry.kind == chde_pkg::ITEM_FINAL);
   end

   // Stage two: join the halves into exact products and drop the fraction
   // bits with a floor shift.
   always_comb begin
      logic signed [FULL_W-1:0] full;
      for (int u = 0; u < UNITS; u++) begin
         for (int k = 0; k < TERMS; k++) begin
            full = (FULL_W'(hi_prod_ff[u][k]) <<< SPLIT_W) + FULL_W'(lo_prod_ff[u][k]);
            prod_in[u][k] = full[FULL_W-1:FRAC_BITS];
         end
      end
   end

   // Commit: complex multiply-add, saturated once per component.
   always_comb begin
      any_sat = 1'b0;
      for (int u = 0; u < UNITS; u++) begin
         sum_re[u] = SUM_W'(prod_ff[u][TERM_RR]) - SUM_W'(prod_ff[u][TERM_II])
                     + SUM_W'(add_re_ff[u]);
         sum_im[u] = SUM_W'(prod_ff[u][TERM_RI]) + SUM_W'(prod_ff[u][TERM_IR])
                     + SUM_W'(add_im_ff[u]);
         new_re[u] = sat_val(sum_re[u]);
         new_im[u] = sat_val(sum_im[u]);
         any_sat   = any_sat || sat_ovf(sum_re[u]) || sat_ovf(sum_im[u]);
      end
      dbl_sat   = dbl_ovf(sum_re[chde_pkg::UNIT_DERIV2]) ||
                  dbl_ovf(sum_im[chde_pkg::UNIT_DERIV2]);
      d2_re_sel = last_ff ? dbl_val(sum_re[chde_pkg::UNIT_DERIV2])
                          : new_re[chde_pkg::UNIT_DERIV2];
      d2_im_sel = last_ff ? dbl_val(sum_im[chde_pkg::UNIT_DERIV2])
                          : new_im[chde_pkg::UNIT_DERIV2];
   end

   always_comb begin
      for (int u = 0; u < UNITS; u++) begin
         acc_re_in[u] = acc_re_ff[u];
         acc_im_in[u] = acc_im_ff[u];
         if (commit) begin
            acc_re_in[u] = last_ff ? '0 : signed'(new_re[u]);
            acc_im_in[u] = last_ff ? '0 : signed'(new_im[u]);
         end
      end
      sat_flag_in = sat_flag_ff;
      if (commit) begin
         sat_flag_in = last_ff ? 1'b0 : (sat_flag_ff || any_sat);
      end
      s1_valid_in  = issue;
      s2_valid_in  = s1_valid_ff || (s2_valid_ff && !commit);
      out_valid_in = commit || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int u = 0; u < UNITS; u++) begin
            acc_re_ff[u] <= '0;
            acc_im_ff[u] <= '0;
         end
         sat_flag_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         acc_re_ff    <= acc_re_in;
         acc_im_ff    <= acc_im_in;
         sat_flag_ff  <= sat_flag_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Addends and the last flag stay in stage one until the commit; nothing
   // new is issued before then.
   always_ff @(posedge clock) begin
      if (issue) begin
         lo_prod_ff <= lo_prod_in;
         hi_prod_ff <= hi_prod_in;
         add_re_ff  <= add_re_in;
         add_im_ff  <= add_im_in;
         last_ff    <= last_in;
      end
      if (s1_valid_ff) begin
         prod_ff <= prod_in;
      end
      if (commit) begin
         out_value_re_ff  <= to_out(new_re[chde_pkg::UNIT_VALUE]);
         out_value_im_ff  <= to_out(new_im[chde_pkg::UNIT_VALUE]);
         out_deriv1_re_ff <= to_out(new_re[chde_pkg::UNIT_DERIV1]);
         out_deriv1_im_ff <= to_out(new_im[chde_pkg::UNIT_DERIV1]);
         out_deriv2_re_ff <= to_out(d2_re_sel);
         out_deriv2_im_ff <= to_out(d2_im_sel);
         out_is_final_ff  <= last_ff;
         out_saturated_ff <= sat_flag_ff || any_sat || (last_ff && dbl_sat);
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_value_re  = out_value_re_ff;
   assign rsp_value_im  = out_value_im_ff;
   assign rsp_deriv1_re = out_deriv1_re_ff;
   assign rsp_deriv1_im = out_deriv1_im_ff;
   assign rsp_deriv2_re = out_deriv2_re_ff;
   assign rsp_deriv2_im = out_deriv2_im_ff;
   assign rsp_is_final  = out_is_final_ff;
   assign rsp_saturated = out_saturated_ff;

   `CHDE_NEVER(a_one_item_in_loop, s1_valid_ff && s2_valid_ff, "two items in the multiply loop")
   `CHDE_ASSERT(a_stage1_advances, s1_valid_ff |=> s2_valid_ff, "stage one item was lost")
   `CHDE_ASSERT(a_issue_fills_stage1, issue |=> s1_valid_ff, "issued item missing in stage one")
   `CHDE_ASSERT(a_final_clears, (commit && last_ff) |=> (!sat_flag_ff && acc_re_ff[chde_pkg::UNIT_VALUE] == '0), "accumulators not cleared after final item")

endmodule

`default_nettype wire
